FILE: hw/rtl/plst_pkg.sv
// plst_pkg: command codes and the shift control word shared by the list store.
// No dependencies; used by plst_ctrl, plst_cells and positional_list_store_core.
`default_nettype none

package plst_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic ins;
    logic del;
  } shift_op_t;

endpackage

`default_nettype wire

FILE: hw/rtl/plst_cells.sv
// plst_cells: row of DEPTH value cells that shift up on insert, down on delete.
// Depends on plst_pkg (shift_op_t); driven by plst_ctrl through the core.
`default_nettype none

module plst_cells #(
  parameter int DEPTH = 16,
  parameter int IW    = $clog2(DEPTH)
) (
  input  wire logic               clk,
  input  wire plst_pkg::shift_op_t op,
  input  wire logic [IW-1:0]      idx,
  input  wire logic signed [31:0] value,
  output logic signed [31:0]      rd_data
);

  logic signed [31:0] cells [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] cell_next;
    always_comb begin
      cell_next = cells[i];
      if (op.ins) begin
        if (IW'(i) == idx) begin
          cell_next = value;
        end else if (IW'(i) > idx) begin
          if (i > 0) cell_next = cells[(i > 0) ? i - 1 : 0];
        end
      end else if (op.del) begin
        if (IW'(i) >= idx && i < DEPTH - 1) begin
          cell_next = cells[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
    always_ff @(posedge clk) begin
      cells[i] <= cell_next;
    end
  end

  assign rd_data = cells[idx];

endmodule

`default_nettype wire

FILE: hw/rtl/plst_ctrl.sv
// plst_ctrl: entry count, validity checks and shift control for one word.
// Depends on plst_pkg (cmd_t, shift_op_t).
`default_nettype none

module plst_ctrl #(
  parameter int DEPTH = 16,
  parameter int IW    = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire logic [1:0]          cmd,
  input  wire logic [7:0]          pos,
  output plst_pkg::shift_op_t      op,
  output logic [IW-1:0]            idx,
  output logic                     ok,
  output logic                     is_read,
  output logic [4:0]               item_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [8:0]    pos_w;
  logic [8:0]    cnt_w;
  logic          full;
  logic          ins_ok;
  logic          del_ok;
  logic          rd_ok;
  logic [31:0]   cnt32;

  assign pos_w = 9'(pos);
  assign cnt_w = 9'(count);
  assign full  = (count == CW'(DEPTH));

  always_comb begin
    ins_ok = 1'b0;
    del_ok = 1'b0;
    rd_ok  = 1'b0;
    unique case (cmd)
      plst_pkg::CMD_INSERT: ins_ok = (pos_w <= cnt_w) && !full;
      plst_pkg::CMD_DELETE: del_ok = (pos_w < cnt_w);
      plst_pkg::CMD_READ:   rd_ok  = (pos_w < cnt_w);
      default: ;
    endcase
  end

  always_comb begin
    count_next = count;
    if (ins_ok) count_next = count + CW'(1);
    else if (del_ok) count_next = count - CW'(1);
  end

  assign ok         = ins_ok || del_ok || rd_ok;
  assign is_read    = rd_ok;
  assign op.ins     = fire && ins_ok;
  assign op.del     = fire && del_ok;
  assign idx        = pos[IW-1:0];
  assign cnt32      = 32'(count_next);
  assign item_count = cnt32[4:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_w <= 9'(DEPTH))
    else $error("entry count above depth");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    op.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not grow the count");

  a_fail_holds: assert property (@(posedge clk) disable iff (rst)
    fire && !ok |=> $stable(count))
    else $error("failed word changed the count");

  a_one_shift: assert property (@(posedge clk) disable iff (rst)
    !(op.ins && op.del))
    else $error("insert and delete together");

endmodule

`default_nettype wire

FILE: hw/rtl/positional_list_store_core.sv
// positional_list_store_core: ordered list of up to DEPTH signed 32-bit values
// with insert, delete and read at a position.
//
// Input stream s_*: one word per command. s_tuser[1:0] = command
// (0 insert, 1 delete, 2 read, 3 no-op). s_tdata = position [7:0],
// value [39:8].
// Output stream m_*: exactly one word per command, in order.
// m_tuser[0] = ok. m_tdata = read_value [31:0], item_count [36:32],
// zero [39:37]. read_value is zero unless a read succeeded; item_count
// is the count after the command.
//
// A word is held in the input register, then the cell row shifts or
// holds and the result register is loaded, which raises m_tvalid.
// One word is taken every cycle while m_tready stays high; count and
// cells update as a word moves into the result register. When the
// receiver stalls, the result register holds its word and the input
// register takes one more before s_tready drops.
// Reset (rst, synchronous) empties the list at once and clears the valid
// flags of both registers; cell contents are left as they are.
// Depends on plst_pkg, plst_ctrl and plst_cells.
`default_nettype none

module positional_list_store_core #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // position[7:0], value[39:8]
  input  wire logic [1:0]  s_tuser,   // command[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // read_value[31:0], item_count[36:32]
  output logic [0:0]       m_tuser    // ok[0]
);

  localparam int IW = $clog2(DEPTH);

  logic               s1_valid;
  logic [1:0]         s1_cmd;
  logic [7:0]         s1_pos;
  logic signed [31:0] s1_value;

  logic               r_ok;
  logic signed [31:0] r_data;
  logic [4:0]         r_count;

  logic               res_free;
  logic               fire;
  plst_pkg::shift_op_t op;
  logic [IW-1:0]      idx;
  logic               ok;
  logic               is_read;
  logic [4:0]         item_count;
  logic signed [31:0] rd_data;

  assign res_free = !m_tvalid || m_tready;
  assign fire     = s1_valid && res_free;
  assign s_tready = !s1_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_cmd   <= s_tuser;
      s1_pos   <= s_tdata[7:0];
      s1_value <= s_tdata[39:8];
    end
  end

  plst_ctrl #(.DEPTH(DEPTH), .IW(IW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .cmd        (s1_cmd),
    .pos        (s1_pos),
    .op         (op),
    .idx        (idx),
    .ok         (ok),
    .is_read    (is_read),
    .item_count (item_count)
  );

  plst_cells #(.DEPTH(DEPTH), .IW(IW)) u_cells (
    .clk     (clk),
    .op      (op),
    .idx     (idx),
    .value   (s1_value),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_free) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      r_ok    <= ok;
      r_data  <= is_read ? rd_data : 32'sd0;
      r_count <= item_count;
    end
  end

  assign m_tdata = {3'b000, r_count, r_data};
  assign m_tuser = r_ok;

endmodule

`default_nettype wire
